// File: hw/rtl/pca_project_and_recon_error_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the projection block checker
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PCA_PROJECT_AND_RECON_ERROR_MACROS_SVH
`define PCA_PROJECT_AND_RECON_ERROR_MACROS_SVH

// same-cycle implication
`define PCAPRE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcapre: same-cycle check failed");

// next-cycle implication
`define PCAPRE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcapre: next-cycle check failed");

`endif

// File: hw/rtl/pcapre_pkg.sv
// ----------------------------------------------------------------------------
// pcapre_pkg
// Types and codes shared by the projection block and its checker.
// ----------------------------------------------------------------------------
package pcapre_pkg;

  typedef enum logic [1:0] {
    REQ_MEAN   = 2'd0,
    REQ_DIR    = 2'd1,
    REQ_VAR    = 2'd2,
    REQ_SAMPLE = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_MISSING  = 2'd1,
    STAT_ZERO_VAR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_INPUT_SIZE = 2'd0,
    CFG_COMP_COUNT = 2'd1,
    CFG_NORMALIZE  = 2'd2,
    CFG_IMPUTE     = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROJ,
    S_PWAIT,
    S_RECON,
    S_RWAIT,
    S_VREAD,
    S_VCHK,
    S_SQRT,
    S_DLOAD,
    S_DIV,
    S_OUT
  } state_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [3:0]         element_index;
    logic [2:0]         component_index;
    logic signed [31:0] data_value;
    logic               value_missing;
  } req_t;

  typedef struct packed {
    logic [2:0]         out_component;
    logic signed [47:0] projection;
    logic               last_component;
    logic [62:0]        recon_error;
    logic               recon_valid;
    status_e            status;
  } res_t;

  localparam logic [62:0] ERR_MAX = {63{1'b1}};

endpackage

// File: hw/rtl/pca_project_and_recon_error.sv
// ----------------------------------------------------------------------------
// pca_project_and_recon_error
// Projects a sample onto stored principal directions and reports the
// squared reconstruction error on the last component result.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  request  | start / busy              | req_i  (load beat or sample element)
//  config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//  result   | res_valid_o (strobe)      | res_o  (one beat per component)
//
//  Load beats and sample elements other than the last leave busy low.
//  The last element of a sample holds busy through the projection pass,
//  a reconstruction pass when no element was missing, then a result
//  step per component, with a bit-serial square root and divider per
//  component in normalize mode. Each multiply pass covers N*K products.
//  No clearing pass after reset; tables are written by load beats.
//  Results cannot be stalled; each beat is on res_o for one cycle.
//
module pca_project_and_recon_error #(
  parameter int MAX_INPUT_SIZE = 16,
  parameter int MAX_COMPONENTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  pcapre_pkg::req_t    req_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output logic                res_valid_o,
  output pcapre_pkg::res_t    res_o
);
  import pcapre_pkg::*;

  // element, component and table address widths
  localparam int EW     = (MAX_INPUT_SIZE > 1) ? $clog2(MAX_INPUT_SIZE) : 1;
  localparam int NW     = EW + 1;
  localparam int CW     = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int KW     = CW + 1;
  localparam int DDEPTH = MAX_COMPONENTS * MAX_INPUT_SIZE;
  localparam int DAW    = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
  localparam int XW     = EW + CW + 4;
  // projection sum, wide product, error accumulator, divider widths
  localparam int PW     = 35 + EW;
  localparam int HW     = PW + 12;
  localparam int FW     = PW + 32;
  localparam int RW     = PW + 2;
  localparam int ERW    = PW + CW + 4;
  localparam int NUMW   = PW + 25;
  localparam int VW     = NUMW + 1;
  localparam int CNTW   = $clog2(NUMW);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [4:0] in_size_q;
  logic [3:0] comp_cnt_q;
  logic       norm_q, impute_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_size_q  <= 5'd16;
      comp_cnt_q <= 4'd2;
      norm_q     <= 1'b0;
      impute_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_INPUT_SIZE: in_size_q  <= cfg_data_i[4:0];
        CFG_COMP_COUNT: comp_cnt_q <= cfg_data_i[3:0];
        CFG_NORMALIZE:  norm_q     <= cfg_data_i[0];
        CFG_IMPUTE:     impute_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective element count n and component count k
  logic [NW-1:0] n_eff;
  logic [KW-1:0] k_eff;

  always_comb begin
    int kmax;
    int kc;
    if (in_size_q == 5'd0) begin
      n_eff = NW'(1);
    end else if (32'(in_size_q) > MAX_INPUT_SIZE) begin
      n_eff = NW'(MAX_INPUT_SIZE);
    end else begin
      n_eff = NW'(in_size_q);
    end
    kmax = (32'(n_eff) < MAX_COMPONENTS) ? 32'(n_eff) : MAX_COMPONENTS;
    kc   = (comp_cnt_q == 4'd0) ? 1 : 32'(comp_cnt_q);
    k_eff = KW'((kc > kmax) ? kmax : kc);
  end

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic            in_acc;
  logic [XW-1:0]   ei_x, ci_x;
  logic            ei_ok, ci_ok, smp_ok, last_idx;
  logic [EW-1:0]   ei_a;
  logic [CW-1:0]   ci_a;
  logic [DAW-1:0]  dir_wa;
  logic            mean_we, dir_we, var_we, smp_we, trigger;

  assign in_acc   = start && !busy;
  assign ei_x     = XW'(req_i.element_index);
  assign ci_x     = XW'(req_i.component_index);
  assign ei_ok    = ei_x < XW'(MAX_INPUT_SIZE);
  assign ci_ok    = ci_x < XW'(MAX_COMPONENTS);
  assign smp_ok   = ei_x < XW'(n_eff);
  assign last_idx = ei_x == (XW'(n_eff) - XW'(1));
  assign ei_a     = ei_x[EW-1:0];
  assign ci_a     = ci_x[CW-1:0];
  assign dir_wa   = DAW'(ci_x * XW'(MAX_INPUT_SIZE) + ei_x);

  assign mean_we = in_acc && (req_i.req_type == REQ_MEAN) && ei_ok;
  assign dir_we  = in_acc && (req_i.req_type == REQ_DIR) && ei_ok && ci_ok;
  assign var_we  = in_acc && (req_i.req_type == REQ_VAR) && ci_ok;
  assign smp_we  = in_acc && (req_i.req_type == REQ_SAMPLE) && smp_ok;
  assign trigger = smp_we && last_idx;

  // --------------------------------------------------------------------------
  // State machine and sequencing counters
  // --------------------------------------------------------------------------
  state_e          state_q, state_d;
  logic [CW-1:0]   ii_q;
  logic [EW-1:0]   jj_q;
  logic [CNTW-1:0] cnt_q;
  logic            ii_last, jj_last, cnt_sq_last, cnt_div_last;
  logic            pipe_empty;
  logic            miss_seen_q;
  logic            unimputed;
  logic signed [31:0] var_rd_q;

  assign ii_last      = {1'b0, ii_q} == (k_eff - KW'(1));
  assign jj_last      = {1'b0, jj_q} == (n_eff - NW'(1));
  assign cnt_sq_last  = cnt_q == CNTW'(31);
  assign cnt_div_last = cnt_q == CNTW'(NUMW - 1);
  assign unimputed    = miss_seen_q && !impute_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (trigger) state_d = S_PROJ;
      S_PROJ:  if (ii_last && jj_last) state_d = S_PWAIT;
      S_PWAIT: if (pipe_empty) state_d = miss_seen_q ? S_VREAD : S_RECON;
      S_RECON: if (ii_last && jj_last) state_d = S_RWAIT;
      S_RWAIT: if (pipe_empty) state_d = S_VREAD;
      S_VREAD: state_d = S_VCHK;
      S_VCHK: begin
        if (!unimputed && norm_q && (var_rd_q > 32'sd0)) state_d = S_SQRT;
        else state_d = S_OUT;
      end
      S_SQRT:  if (cnt_sq_last) state_d = S_DLOAD;
      S_DLOAD: state_d = S_DIV;
      S_DIV:   if (cnt_div_last) state_d = S_OUT;
      S_OUT:   state_d = ii_last ? S_IDLE : S_VREAD;
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs of the state machine
  logic issue, issue_ph;

  always_comb begin
    busy     = 1'b1;
    issue    = 1'b0;
    issue_ph = 1'b0;
    unique case (state_q)
      S_IDLE:  busy = 1'b0;
      S_PROJ:  issue = 1'b1;
      S_RECON: begin
        issue    = 1'b1;
        issue_ph = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ii_q    <= '0;
      jj_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          ii_q <= '0;
          jj_q <= '0;
        end
        // projection: components outer, elements inner
        S_PROJ: begin
          if (jj_last) begin
            jj_q <= '0;
            ii_q <= ii_last ? '0 : ii_q + CW'(1);
          end else begin
            jj_q <= jj_q + EW'(1);
          end
        end
        // reconstruction: elements outer, components inner
        S_RECON: begin
          if (ii_last) begin
            ii_q <= '0;
            jj_q <= jj_last ? '0 : jj_q + EW'(1);
          end else begin
            ii_q <= ii_q + CW'(1);
          end
        end
        S_VCHK, S_DLOAD: cnt_q <= '0;
        S_SQRT, S_DIV:   cnt_q <= cnt_q + CNTW'(1);
        S_OUT:   ii_q <= ii_last ? '0 : ii_q + CW'(1);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Table memories: written by load beats and sample elements while idle,
  // read while busy, so reads and writes never overlap on one entry.
  // --------------------------------------------------------------------------
  logic signed [31:0] mean_mem [MAX_INPUT_SIZE];
  logic signed [31:0] smp_mem  [MAX_INPUT_SIZE];
  logic signed [31:0] dir_mem  [DDEPTH];
  logic signed [31:0] var_mem  [MAX_COMPONENTS];
  logic signed [31:0] mean_rd_q, smp_rd_q, dir_rd_q;
  logic [DAW-1:0]     dir_ra;

  assign dir_ra = DAW'(XW'(ii_q) * XW'(MAX_INPUT_SIZE) + XW'(jj_q));

  always_ff @(posedge clk_i) begin
    if (mean_we) mean_mem[ei_a] <= req_i.data_value;
    mean_rd_q <= mean_mem[jj_q];
  end

  always_ff @(posedge clk_i) begin
    if (smp_we) smp_mem[ei_a] <= req_i.data_value;
    smp_rd_q <= smp_mem[jj_q];
  end

  always_ff @(posedge clk_i) begin
    if (dir_we) dir_mem[dir_wa] <= req_i.data_value;
    dir_rd_q <= dir_mem[dir_ra];
  end

  always_ff @(posedge clk_i) begin
    if (var_we) var_mem[ci_a] <= req_i.data_value;
    var_rd_q <= var_mem[ii_q];
  end

  // Missing marks: cleared at reset and after each sample
  logic [MAX_INPUT_SIZE-1:0] marks_q;
  logic                      sample_done;

  assign sample_done = (state_q == S_OUT) && ii_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q     <= '0;
      miss_seen_q <= 1'b0;
    end else if (sample_done) begin
      marks_q     <= '0;
      miss_seen_q <= 1'b0;
    end else if (smp_we) begin
      marks_q[ei_a] <= req_i.value_missing;
      if (req_i.value_missing) miss_seen_q <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Multiply pipeline, shared by projection and reconstruction passes
  //   s1: table read    s2: centre    s3: multiply    s4: accumulate
  //   s5/s6: square and add to the error (reconstruction only)
  // --------------------------------------------------------------------------
  logic                 v1_q, ph1_q, first1_q, last1_q;
  logic [CW-1:0]        i1_q;
  logic [EW-1:0]        j1_q;
  logic                 v2_q, ph2_q, first2_q, last2_q;
  logic [CW-1:0]        i2_q;
  logic signed [32:0]   c2_q;
  logic signed [31:0]   d2_q;
  logic signed [PW-1:0] p2_q;
  logic                 v3_q, ph3_q, first3_q, last3_q;
  logic [CW-1:0]        i3_q;
  logic signed [32:0]   c3_q;
  logic signed [64:0]   prod3_q;
  logic signed [52:0]   plo3_q;
  logic signed [HW-1:0] phi3_q;
  logic                 v5_q, v6_q, big6_q;
  logic signed [ERW-1:0] e_q, e5_q;
  logic [45:0]          hh6_q;
  logic [38:0]          hl6_q;
  logic [31:0]          ll6_q;
  logic [62:0]          err_q;
  logic signed [PW-1:0] acc_q [MAX_COMPONENTS];

  assign pipe_empty = !(v1_q || v2_q || v3_q || v5_q || v6_q);

  // s2: pick the sample or the imputed mean, subtract the mean
  logic signed [31:0] x_sel;
  logic signed [32:0] c_n;

  always_comb begin
    x_sel = (marks_q[j1_q] && impute_q) ? mean_rd_q : smp_rd_q;
    c_n   = $signed({x_sel[31], x_sel}) - $signed({mean_rd_q[31], mean_rd_q});
  end

  // s4: round the products by 2^30, half up
  logic signed [64:0]  prod_r;
  logic signed [34:0]  pterm;
  logic signed [FW-1:0] full, full_r;
  logic signed [RW-1:0] rterm;
  logic signed [ERW-1:0] e_n;

  always_comb begin
    prod_r = prod3_q + $signed(65'(32'd536870912));
    pterm  = 35'(prod_r >>> 30);
    full   = (FW'(phi3_q) <<< 20) + FW'(plo3_q);
    full_r = full + $signed(FW'(32'd536870912));
    rterm  = RW'(full_r >>> 30);
    e_n    = (first3_q ? ERW'(c3_q) : e_q) - ERW'(rterm);
  end

  // s5: split the error magnitude for the square
  logic [ERW-1:0] e_abs;
  logic           big5;
  logic [38:0]    a5;

  always_comb begin
    e_abs = e5_q[ERW-1] ? ERW'(-e5_q) : ERW'(e5_q);
    big5  = |e_abs[ERW-1:39];
    a5    = e_abs[38:0];
  end

  // s6: assemble the rounded square, add with saturation
  logic [62:0] sq_term;
  logic [63:0] err_sum;

  always_comb begin
    sq_term = big6_q ? ERR_MAX
                     : 63'({hh6_q, 16'd0}) + 63'({hl6_q, 1'b0})
                       + 63'((33'(ll6_q) + 33'h8000) >> 16);
    err_sum = {1'b0, err_q} + {1'b0, sq_term};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v5_q <= v3_q && ph3_q && last3_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // s1 tags
    ph1_q    <= issue_ph;
    i1_q     <= ii_q;
    j1_q     <= jj_q;
    first1_q <= issue_ph ? (ii_q == '0) : (jj_q == '0);
    last1_q  <= ii_last;
    // s2
    ph2_q    <= ph1_q;
    i2_q     <= i1_q;
    first2_q <= first1_q;
    last2_q  <= last1_q;
    c2_q     <= c_n;
    d2_q     <= dir_rd_q;
    p2_q     <= acc_q[i1_q];
    // s3
    ph3_q    <= ph2_q;
    i3_q     <= i2_q;
    first3_q <= first2_q;
    last3_q  <= last2_q;
    c3_q     <= c2_q;
    prod3_q  <= c2_q * d2_q;
    plo3_q   <= d2_q * $signed({1'b0, p2_q[19:0]});
    phi3_q   <= d2_q * $signed(p2_q[PW-1:20]);
    // s4
    if (v3_q && !ph3_q) begin
      acc_q[i3_q] <= first3_q ? PW'(pterm) : acc_q[i3_q] + PW'(pterm);
    end
    if (v3_q && ph3_q) begin
      e_q <= e_n;
      if (last3_q) e5_q <= e_n;
    end
    // s5
    big6_q <= big5;
    hh6_q  <= a5[38:16] * a5[38:16];
    hl6_q  <= a5[38:16] * a5[15:0];
    ll6_q  <= a5[15:0] * a5[15:0];
    // s6
    if (trigger) begin
      err_q <= '0;
    end else if (v6_q) begin
      err_q <= err_sum[63] ? ERR_MAX : err_sum[62:0];
    end
  end

  // --------------------------------------------------------------------------
  // Normalization: bit-serial square root, then bit-serial divider
  // --------------------------------------------------------------------------
  logic [35:0]     rem_q, rem_n;
  logic [31:0]     root_q;
  logic [63:0]     src_q;
  logic [35:0]     sq_trial;
  logic [32:0]     dr_q, d_trial;
  logic [NUMW-1:0] num_q, quo_q;
  logic [PW-1:0]   acc_mag;
  logic            norm_use_q;
  status_e         st_q;

  always_comb begin
    rem_n    = {rem_q[33:0], src_q[63:62]};
    sq_trial = {2'b00, root_q, 2'b01};
    d_trial  = {dr_q[31:0], num_q[NUMW-1]};
    acc_mag  = acc_q[ii_q][PW-1] ? PW'(-acc_q[ii_q]) : PW'(acc_q[ii_q]);
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_VCHK: begin
        src_q      <= {var_rd_q, 32'd0};
        rem_q      <= '0;
        root_q     <= '0;
        norm_use_q <= 1'b0;
        if (unimputed) begin
          st_q <= STAT_MISSING;
        end else if (norm_q && (var_rd_q <= 32'sd0)) begin
          st_q <= STAT_ZERO_VAR;
        end else begin
          st_q       <= STAT_OK;
          norm_use_q <= norm_q;
        end
      end
      S_SQRT: begin
        src_q <= {src_q[61:0], 2'b00};
        if (rem_n >= sq_trial) begin
          rem_q  <= rem_n - sq_trial;
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= rem_n;
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      S_DLOAD: begin
        num_q <= (NUMW'(acc_mag) << 24) + NUMW'(root_q >> 1);
        quo_q <= '0;
        dr_q  <= '0;
      end
      S_DIV: begin
        num_q <= {num_q[NUMW-2:0], 1'b0};
        if (d_trial >= {1'b0, root_q}) begin
          dr_q  <= d_trial - {1'b0, root_q};
          quo_q <= {quo_q[NUMW-2:0], 1'b1};
        end else begin
          dr_q  <= d_trial;
          quo_q <= {quo_q[NUMW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Result beat
  // --------------------------------------------------------------------------
  logic signed [VW-1:0] pv;
  logic signed [47:0]   p_sat;

  always_comb begin
    if (norm_use_q) begin
      pv = acc_q[ii_q][PW-1] ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    end else begin
      pv = VW'(acc_q[ii_q]);
    end
    if (pv > $signed(VW'(48'h7FFF_FFFF_FFFF))) begin
      p_sat = 48'sh7FFF_FFFF_FFFF;
    end else if (pv < -$signed(VW'(49'h0_8000_0000_0000))) begin
      p_sat = 48'sh8000_0000_0000;
    end else begin
      p_sat = pv[47:0];
    end
  end

  logic res_valid_q;
  res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (state_q == S_OUT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT) begin
      res_q.out_component  <= 3'(ii_q);
      res_q.projection     <= (st_q == STAT_OK) ? p_sat : 48'sd0;
      res_q.last_component <= ii_last;
      res_q.recon_error    <= (ii_last && !miss_seen_q) ? err_q : '0;
      res_q.recon_valid    <= ii_last && !miss_seen_q;
      res_q.status         <= st_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: hw/rtl/pcapre_checker.sv
// ----------------------------------------------------------------------------
// pcapre_checker
// Port-level checks on the result beats of the projection block.
// ----------------------------------------------------------------------------
`include "pca_project_and_recon_error_macros.svh"

module pcapre_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             busy,
  input logic             res_valid_o,
  input pcapre_pkg::res_t res_o
);
  import pcapre_pkg::*;

  // results only come out of a busy sample
  `PCAPRE_ASSERT_IMP(a_res_after_busy, res_valid_o, $past(busy))
  // component beats are spaced apart
  `PCAPRE_ASSERT_NXT(a_res_spaced, res_valid_o, !res_valid_o)
  // more beats pending after a non-final beat, so no new request may enter
  `PCAPRE_ASSERT_NXT(a_more_pending, res_valid_o && !res_o.last_component, busy)
  // only the final beat carries the error
  `PCAPRE_ASSERT_IMP(a_err_last_only, res_valid_o && !res_o.last_component,
                     !res_o.recon_valid && (res_o.recon_error == '0))
  // missing without imputation zeroes the projection and clears recon_valid
  `PCAPRE_ASSERT_IMP(a_missing_zero, res_valid_o && (res_o.status == STAT_MISSING),
                     !res_o.recon_valid && (res_o.projection == '0))

endmodule

bind pca_project_and_recon_error pcapre_checker u_pcapre_checker (.*);
